>>> rtl/esc_pkg.sv
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the epoch-to-calendar unit
// Command/status structs between controller and datapath, reciprocal
// constants for the time split and the month length lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

  // Unit sizes in seconds
  localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
  localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;

  // Reciprocals: floor(x / d) = (x * R) >> S, exact over each dividend range.
  // Power-of-two factors of the divisor are shifted off the dividend first.
  localparam logic [25:0] DAY_RECIP  = 26'd50903317; // 2^35 / 675, x = secs >> 7
  localparam logic [13:0] HOUR_RECIP = 14'd9321;     // 2^21 / 225, x = tod >> 4
  localparam logic [10:0] MIN_RECIP  = 11'd1093;     // 2^14 / 15, x = rem >> 2
  localparam logic [16:0] WEEK_RECIP = 17'd74899;    // 2^19 / 7, x = days

  // Calendar constants
  localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
  localparam logic [6:0]  EPOCH_YEAR_100 = 7'd70;   // 1970 mod 100
  localparam logic [8:0]  EPOCH_YEAR_400 = 9'd370;  // 1970 mod 400
  localparam logic [2:0]  EPOCH_WEEKDAY  = 3'd4;    // Thursday
  localparam logic [3:0]  MONTH_FEB      = 4'd1;
  localparam logic [3:0]  MONTH_DEC      = 4'd11;

  // Controller to datapath commands
  typedef struct packed {
    logic start;       // capture input
    logic day_div;     // whole days from the seconds count
    logic tod_calc;    // time of day, weekday quotient, set up year walk
    logic hour_div;    // hour from the time of day
    logic mrem_calc;   // seconds within the hour
    logic min_div;     // minute from the seconds within the hour
    logic sec_calc;    // second within the minute
    logic year_step;   // take one year off the day count
    logic month_step;  // take one month off the day count
    logic out_load;    // load the result register
  } esc_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic year_done;
    logic month_done;
  } esc_status_t;

  // Month length with February at 29 in leap years
  function automatic logic [4:0] month_len(input logic [3:0] mon, input logic leap);
    logic [4:0] len;
    begin
      case (mon)
        4'd1:                   len = 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
        default:                len = 5'd31;
      endcase
      if (mon == MONTH_FEB && leap) begin
        len = 5'd29;
      end
      return len;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/esc_ctrl.sv
// ----------------------------------------------------------------------------
// esc_ctrl: sequencing controller
// Walks the datapath through the day, hour and minute split, the year walk
// and the month walk, and owns the input stall and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire                  out_stall,
  input  esc_pkg::esc_status_t status,
  output esc_pkg::esc_cmd_t    cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DAY   = 10'b0000000010,
    S_TOD   = 10'b0000000100,
    S_HOUR  = 10'b0000001000,
    S_MREM  = 10'b0000010000,
    S_MIN   = 10'b0000100000,
    S_SEC   = 10'b0001000000,
    S_YEAR  = 10'b0010000000,
    S_MONTH = 10'b0100000000,
    S_DONE  = 10'b1000000000
  } state_t;

  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and command decode
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    // result taken by the receiver
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_DAY;
        end
      end
      S_DAY: begin
        cmd.day_div = 1'b1;
        state_nxt   = S_TOD;
      end
      S_TOD: begin
        cmd.tod_calc = 1'b1;
        state_nxt    = S_HOUR;
      end
      S_HOUR: begin
        cmd.hour_div = 1'b1;
        state_nxt    = S_MREM;
      end
      S_MREM: begin
        cmd.mrem_calc = 1'b1;
        state_nxt     = S_MIN;
      end
      S_MIN: begin
        cmd.min_div = 1'b1;
        state_nxt   = S_SEC;
      end
      S_SEC: begin
        cmd.sec_calc = 1'b1;
        state_nxt    = S_YEAR;
      end
      S_YEAR: begin
        if (status.year_done) begin
          state_nxt = S_MONTH;
        end else begin
          cmd.year_step = 1'b1;
        end
      end
      S_MONTH: begin
        if (status.month_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/esc_dpath.sv
// ----------------------------------------------------------------------------
// esc_dpath: conversion datapath
// Splits the seconds count into days, hour, minute and second by reciprocal
// multiplication, reduces days mod 7 for the weekday, runs the year and
// month walk and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_dpath (
  input  wire                  clk,
  input  esc_pkg::esc_cmd_t    cmd,
  output esc_pkg::esc_status_t status,
  input  wire  [31:0]          in_epoch_seconds,
  output logic [5:0]           out_second,
  output logic [5:0]           out_minute,
  output logic [4:0]           out_hour,
  output logic [4:0]           out_day_of_month,
  output logic [3:0]           out_month,
  output logic [11:0]          out_year,
  output logic [2:0]           out_weekday
);

  // time split
  logic [31:0] sec_r;
  logic [15:0] days_r;
  logic [16:0] tod_r;
  logic [13:0] wq_r;
  logic [4:0]  hour_r;
  logic [11:0] mrem_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [50:0] day_prod;
  logic [32:0] week_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [31:0] day_secs;
  logic [16:0] hour_secs;
  logic [11:0] min_secs;
  // calendar walk
  logic [15:0] drem_r;
  logic [11:0] year_r;
  logic [6:0]  y100_r;
  logic [8:0]  y400_r;
  logic [3:0]  mon_r;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  // result
  logic [2:0]  wrem;
  logic [3:0]  wday_sum;
  logic [2:0]  wday;
  logic [5:0]  out_second_r, out_minute_r;
  logic [4:0]  out_hour_r, out_day_r;
  logic [3:0]  out_month_r;
  logic [11:0] out_year_r;
  logic [2:0]  out_weekday_r;

  // Reciprocal products, quotient taken from the upper bits
  assign day_prod  = 51'(sec_r[31:7]) * 51'(esc_pkg::DAY_RECIP);
  assign week_prod = 33'(days_r) * 33'(esc_pkg::WEEK_RECIP);
  assign hour_prod = 27'(tod_r[16:4]) * 27'(esc_pkg::HOUR_RECIP);
  assign min_prod  = 21'(mrem_r[11:2]) * 21'(esc_pkg::MIN_RECIP);

  // Quotient back to seconds, for the remainders
  assign day_secs  = 32'(days_r) * esc_pkg::SECS_PER_DAY;
  assign hour_secs = 17'(hour_r) * esc_pkg::SECS_PER_HOUR;
  assign min_secs  = 12'(minute_r) * esc_pkg::SECS_PER_MIN;

  // Gregorian leap rule from the running year residues
  assign leap = (year_r[1:0] == 2'd0) && ((y100_r != 7'd0) || (y400_r == 9'd0));
  assign ylen = leap ? 9'd366 : 9'd365;
  assign mlen = esc_pkg::month_len(mon_r, leap);

  assign status.year_done  = (drem_r < 16'(ylen));
  assign status.month_done = (mon_r == esc_pkg::MONTH_DEC) || (drem_r < 16'(mlen));

  // Weekday: days mod 7 is days + days/7 mod 8, then add Thursday
  assign wrem     = 3'(days_r[2:0] + wq_r[2:0]);
  assign wday_sum = {1'b0, wrem} + {1'b0, esc_pkg::EPOCH_WEEKDAY};
  assign wday     = (wday_sum >= 4'd7) ? 3'(wday_sum - 4'd7) : wday_sum[2:0];

  // Time split registers, one stage per command
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      sec_r <= in_epoch_seconds;
    end
    if (cmd.day_div) begin
      days_r <= day_prod[50:35];
    end
    if (cmd.tod_calc) begin
      tod_r <= 17'(sec_r - day_secs);
      wq_r  <= week_prod[32:19];
    end
    if (cmd.hour_div) begin
      hour_r <= hour_prod[25:21];
    end
    if (cmd.mrem_calc) begin
      mrem_r <= 12'(tod_r - hour_secs);
    end
    if (cmd.min_div) begin
      minute_r <= min_prod[19:14];
    end
    if (cmd.sec_calc) begin
      second_r <= 6'(mrem_r - min_secs);
    end
  end

  // Calendar walk
  always_ff @(posedge clk) begin
    if (cmd.tod_calc) begin
      drem_r <= days_r;
      year_r <= esc_pkg::EPOCH_YEAR;
      y100_r <= esc_pkg::EPOCH_YEAR_100;
      y400_r <= esc_pkg::EPOCH_YEAR_400;
      mon_r  <= '0;
    end else if (cmd.year_step) begin
      drem_r <= drem_r - 16'(ylen);
      year_r <= year_r + 12'd1;
      y100_r <= (y100_r == 7'd99)  ? 7'd0 : y100_r + 7'd1;
      y400_r <= (y400_r == 9'd399) ? 9'd0 : y400_r + 9'd1;
    end else if (cmd.month_step) begin
      drem_r <= drem_r - 16'(mlen);
      mon_r  <= mon_r + 4'd1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_second_r  <= second_r;
      out_minute_r  <= minute_r;
      out_hour_r    <= hour_r;
      out_day_r     <= drem_r[4:0] + 5'd1;
      out_month_r   <= mon_r;
      out_year_r    <= year_r;
      out_weekday_r <= wday;
    end
  end

  assign out_second       = out_second_r;
  assign out_minute       = out_minute_r;
  assign out_hour         = out_hour_r;
  assign out_day_of_month = out_day_r;
  assign out_month        = out_month_r;
  assign out_year         = out_year_r;
  assign out_weekday      = out_weekday_r;

endmodule

`default_nettype wire

>>> rtl/epoch_seconds_to_calendar_unit.sv
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: epoch seconds to Gregorian date and time
// Splits an unsigned 32-bit seconds count since 1970-01-01 00:00:00 into
// second, minute, hour, day of month, month, year and weekday.
//
// Usage:
//   Input channel in_valid/in_stall carries in_epoch_seconds; the result
//   channel out_valid/out_stall carries the seven calendar fields, one
//   result per input. A transfer happens when valid is high and stall low.
//   After an input transfer the controller steps through day, time of day,
//   hour, seconds within the hour, minute and second to split the seconds
//   by reciprocal multiplication, then walks the whole years after 1970
//   (0..136) and the months (index 0..11), one per step, each walk ending
//   with a check step, and finally loads the result. A new input is taken
//   only after the previous conversion has loaded its result.
//   The unit takes a new input while the previous result waits in the
//   output register; if the receiver still stalls when the next result is
//   ready, the unit holds it and keeps in_stall high.
//   Synchronous reset clears the controller and drops out_valid; the
//   datapath registers have no reset.
// ----------------------------------------------------------------------------
`default_nettype none

module epoch_seconds_to_calendar_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [5:0]  out_second,
  output logic [5:0]  out_minute,
  output logic [4:0]  out_hour,
  output logic [4:0]  out_day_of_month,
  output logic [3:0]  out_month,
  output logic [11:0] out_year,
  output logic [2:0]  out_weekday
);

  esc_pkg::esc_cmd_t    cmd;
  esc_pkg::esc_status_t status;

  // Sequencing controller
  esc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Time split, calendar walk and result register
  esc_dpath u_dpath (
    .clk              (clk),
    .cmd              (cmd),
    .status           (status),
    .in_epoch_seconds (in_epoch_seconds),
    .out_second       (out_second),
    .out_minute       (out_minute),
    .out_hour         (out_hour),
    .out_day_of_month (out_day_of_month),
    .out_month        (out_month),
    .out_year         (out_year),
    .out_weekday      (out_weekday)
  );

endmodule

`default_nettype wire

>>> rtl/esc_checker.sv
// ----------------------------------------------------------------------------
// esc_checker: port-level checks for the epoch-to-calendar unit
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_stall,
  input wire [31:0] in_epoch_seconds,
  input wire        out_valid,
  input wire        out_stall,
  input wire [5:0]  out_second,
  input wire [5:0]  out_minute,
  input wire [4:0]  out_hour,
  input wire [4:0]  out_day_of_month,
  input wire [3:0]  out_month,
  input wire [11:0] out_year,
  input wire [2:0]  out_weekday
);

  // stalled result stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // unit is busy right after an input transfer
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a conversion is running");

  // a conversion never finishes in the cycle after it starts
  a_no_early_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // all result fields stay in their calendar ranges
  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_second < 6'd60) && (out_minute < 6'd60) && (out_hour < 5'd24) &&
                  (out_day_of_month != 5'd0) && (out_month < 4'd12) &&
                  (out_year >= 12'd1970) && (out_year <= 12'd2106) && (out_weekday < 3'd7))
    else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar_unit esc_checker u_esc_checker (.*);

`default_nettype wire
